// ----- hdl/cbor_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CBOR head decoder package
// Shared token types, codes and float widening helpers.
// ----------------------------------------------------------------------------
package cbor_pkg;

	localparam logic [1:0] KIND_HEAD    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_RESERVED  = 2'd1;
	localparam logic [1:0] ERR_TRUNC_ARG = 2'd2;
	localparam logic [1:0] ERR_TRUNC_PAY = 2'd3;

	localparam logic [2:0] MAJ_BYTES = 3'd2;
	localparam logic [2:0] MAJ_TEXT  = 3'd3;
	localparam logic [2:0] MAJ_SIMPLE = 3'd7;

	localparam logic [4:0] INFO_DIRECT_LIMIT = 5'd24;
	localparam logic [4:0] INFO_HALF   = 5'd25;
	localparam logic [4:0] INFO_SINGLE = 5'd26;
	localparam logic [4:0] INFO_DOUBLE = 5'd27;

	localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] INF64  = 64'h7FF0_0000_0000_0000;

	localparam int TOKEN_FIFO_DEPTH = 4;

	// Raw item handed from front to back: up to two beats in one entry.
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  major;
		logic [4:0]  info;
		logic [63:0] arg;
		logic [7:0]  pbyte;
		logic        plast;
		logic [1:0]  err;
	} token_t;

	typedef struct packed {
		token_t t0;
		token_t t1;
		logic   two;
	} front_entry_t;

	function automatic logic [63:0] widen_half(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [63:0] mag;
		logic [3:0]  p;
		logic [51:0] sh;
		e = h[14:10];
		m = h[9:0];
		p = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (m[i]) p = 4'(i);
		end
		sh = 52'(m) << (6'd52 - 6'(p));
		if (e == 5'd31) mag = (m == 10'd0) ? INF64 : QNAN64;
		else if (e == 5'd0) begin
			if (m == 10'd0) mag = 64'd0;
			else mag = {1'b0, 11'(11'd999 + 11'(p)), sh};
		end else mag = {1'b0, 11'(11'd1008 + 11'(e)), m, 42'd0};
		return {h[15], mag[62:0]};
	endfunction

	function automatic logic [63:0] widen_single(input logic [31:0] f);
		logic [7:0]  e;
		logic [22:0] m;
		logic [63:0] mag;
		logic [4:0]  p;
		logic [51:0] sh;
		e = f[30:23];
		m = f[22:0];
		p = 5'd0;
		for (int i = 1; i < 23; i++) begin
			if (m[i]) p = 5'(i);
		end
		sh = 52'(m) << (6'd52 - 6'(p));
		if (e == 8'hFF) mag = (m == 23'd0) ? INF64 : (QNAN64 | {12'd0, m, 29'd0});
		else if (e == 8'd0) begin
			if (m == 23'd0) mag = 64'd0;
			else mag = {1'b0, 11'(11'd874 + 11'(p)), sh};
		end else mag = {1'b0, 11'(11'd896 + 11'(e)), m, 29'd0};
		return {f[31], mag[62:0]};
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cbor_item_head_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CBOR item head decoder
// Byte-wide CBOR head parser with payload pass-through and float widening.
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle whenever push is high and full is low,
// so the block sustains one byte per clock. The front parser updates its
// phase, argument accumulator and payload counter on each taken byte and
// drops at most one entry (one or two result beats) into a small queue of
// Depth entries. The back end drains one beat per pop from the queue head;
// float widening is done on the queue read side. Full rises only when the
// queue holds Depth entries; an entry with two beats (head or payload
// followed by a truncation error) takes two pops to drain.
// ----------------------------------------------------------------------------
module cbor_item_head_decoder import cbor_pkg::*; #(
	parameter int Depth = TOKEN_FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_buffer,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       token_kind,
	output logic [2:0]       major_type,
	output logic [4:0]       additional_info,
	output logic [63:0]      argument,
	output logic [63:0]      float_bits,
	output logic             is_float,
	output logic [7:0]       payload_byte,
	output logic             payload_last,
	output logic [1:0]       error_code
);
	logic         take;
	logic         ent_valid;
	front_entry_t ent;

	// a byte beat is consumed whenever push is high and the queue has room
	assign take = push && !full;

	cbor_front u_front (
		.clk, .arst_n, .take, .in_byte, .end_of_buffer,
		.ent_valid, .ent
	);

	cbor_back #(.Depth(Depth)) u_back (
		.clk, .arst_n,
		.wr(ent_valid), .wr_ent(ent),
		.full, .empty, .pop,
		.token_kind, .major_type, .additional_info, .argument,
		.float_bits, .is_float, .payload_byte, .payload_last, .error_code
	);

	// error beats carry a nonzero code, other beats none
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((token_kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match token kind");

	// only heads are floats
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_float) |-> (token_kind == KIND_HEAD && major_type == MAJ_SIMPLE))
		else $error("float flag on non-float beat");

	// a stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(token_kind) && $stable(argument)))
		else $error("output beat changed while stalled");
endmodule
`default_nettype wire

// ----- hdl/cbor_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CBOR front parser
// Accepts one byte per beat, tracks parse phase, builds raw tokens.
// ----------------------------------------------------------------------------
module cbor_front import cbor_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         take,
	input  wire logic [7:0]   in_byte,
	input  wire logic         end_of_buffer,
	output logic              ent_valid,
	output front_entry_t      ent
);
	localparam logic [1:0] PH_INIT = 2'd0;
	localparam logic [1:0] PH_ARG  = 2'd1;
	localparam logic [1:0] PH_PAY  = 2'd2;

	logic [1:0]  phase_q;
	logic [3:0]  arg_left_q;
	logic [63:0] acc_q;
	logic [2:0]  maj_q;
	logic [4:0]  info_q;
	logic [63:0] pay_left_q;

	logic [1:0]  phase_d;
	logic [3:0]  arg_left_d;
	logic [63:0] acc_d;
	logic [2:0]  maj_d;
	logic [4:0]  info_d;
	logic [63:0] pay_left_d;
	logic        fin;
	logic [63:0] fin_arg;
	token_t      blank;

	always_comb begin
		blank = '0;
		phase_d = phase_q; arg_left_d = arg_left_q; acc_d = acc_q;
		maj_d = maj_q; info_d = info_q; pay_left_d = pay_left_q;
		ent_valid = 1'b0;
		ent = '0;
		fin = 1'b0;
		fin_arg = 64'd0;
		if (phase_q == PH_ARG) begin
			acc_d = {acc_q[55:0], in_byte};
			arg_left_d = arg_left_q - 4'd1;
			if (arg_left_d == 4'd0) begin
				fin = 1'b1;
				fin_arg = acc_d;
			end else if (end_of_buffer) begin
				phase_d = PH_INIT;
				arg_left_d = 4'd0;
				ent_valid = 1'b1;
				ent.t0 = blank;
				ent.t0.kind = KIND_ERROR;
				ent.t0.err = ERR_TRUNC_ARG;
			end
		end else if (phase_q == PH_PAY) begin
			pay_left_d = pay_left_q - 64'd1;
			ent_valid = 1'b1;
			ent.t0.kind = KIND_PAYLOAD;
			ent.t0.pbyte = in_byte;
			if (pay_left_d == 64'd0) begin
				phase_d = PH_INIT;
				ent.t0.plast = 1'b1;
			end else if (end_of_buffer) begin
				phase_d = PH_INIT;
				pay_left_d = 64'd0;
				ent.two = 1'b1;
				ent.t1.kind = KIND_ERROR;
				ent.t1.err = ERR_TRUNC_PAY;
			end
		end else begin
			phase_d = PH_INIT;
			maj_d = in_byte[7:5];
			info_d = in_byte[4:0];
			if (info_d < INFO_DIRECT_LIMIT) begin
				fin = 1'b1;
				fin_arg = 64'(info_d);
			end else if (info_d <= INFO_DOUBLE) begin
				acc_d = 64'd0;
				arg_left_d = 4'd1 << info_d[1:0];
				if (end_of_buffer) begin
					arg_left_d = 4'd0;
					ent_valid = 1'b1;
					ent.t0.kind = KIND_ERROR;
					ent.t0.err = ERR_TRUNC_ARG;
				end else phase_d = PH_ARG;
			end else begin
				ent_valid = 1'b1;
				ent.t0.kind = KIND_ERROR;
				ent.t0.err = ERR_RESERVED;
			end
		end
		if (fin) begin
			phase_d = PH_INIT;
			ent_valid = 1'b1;
			ent.t0.kind = KIND_HEAD;
			ent.t0.arg = fin_arg;
			if ((maj_d == MAJ_BYTES || maj_d == MAJ_TEXT) && fin_arg != 64'd0) begin
				if (end_of_buffer) begin
					ent.two = 1'b1;
					ent.t1.kind = KIND_ERROR;
					ent.t1.err = ERR_TRUNC_PAY;
				end else begin
					pay_left_d = fin_arg;
					phase_d = PH_PAY;
				end
			end
		end
		ent.t0.major = maj_d;
		ent.t0.info = info_d;
		ent.t1.major = maj_d;
		ent.t1.info = info_d;
		ent_valid = ent_valid & take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			arg_left_q <= '0;
			acc_q <= '0;
			maj_q <= '0;
			info_q <= '0;
			pay_left_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			arg_left_q <= arg_left_d;
			acc_q <= acc_d;
			maj_q <= maj_d;
			info_q <= info_d;
			pay_left_q <= pay_left_d;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/cbor_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CBOR back end
// Queue of raw entries; splits two-beat entries and widens floats on output.
// ----------------------------------------------------------------------------
module cbor_back import cbor_pkg::*; #(
	parameter int Depth = TOKEN_FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr,
	input  front_entry_t     wr_ent,
	output logic             full,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       token_kind,
	output logic [2:0]       major_type,
	output logic [4:0]       additional_info,
	output logic [63:0]      argument,
	output logic [63:0]      float_bits,
	output logic             is_float,
	output logic [7:0]       payload_byte,
	output logic             payload_last,
	output logic [1:0]       error_code
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	front_entry_t        mem_q [Depth];
	logic [AW-1:0]       wp_q, rp_q;
	logic [AW:0]         cnt_q;
	logic                second_q;
	token_t              cur;
	logic                rd;

	assign full  = (cnt_q == (AW+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign cur   = second_q ? mem_q[rp_q].t1 : mem_q[rp_q].t0;
	assign rd    = pop && !empty && (second_q || !mem_q[rp_q].two);

	always_comb begin
		token_kind = cur.kind;
		major_type = cur.major;
		additional_info = cur.info;
		argument = cur.arg;
		payload_byte = cur.pbyte;
		payload_last = cur.plast;
		error_code = cur.err;
		is_float = 1'b0;
		float_bits = 64'd0;
		if (cur.kind == KIND_HEAD && cur.major == MAJ_SIMPLE) begin
			if (cur.info == INFO_HALF) begin
				is_float = 1'b1;
				float_bits = widen_half(cur.arg[15:0]);
			end else if (cur.info == INFO_SINGLE) begin
				is_float = 1'b1;
				float_bits = widen_single(cur.arg[31:0]);
			end else if (cur.info == INFO_DOUBLE) begin
				is_float = 1'b1;
				float_bits = cur.arg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			second_q <= 1'b0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			if (pop && !empty) second_q <= !rd;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire
